/* rtl/h264rtp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package h264rtp_pkg;

	// widest field sizes over the parameter ranges; modules truncate to their own
	localparam int CMD_LEN_W = 16;
	localparam int CMD_OFF_W = 32;

	localparam logic [15:0] MIN_PAYLOAD    = 16'd300;
	localparam logic [4:0]  STAP_A_TYPE    = 5'd24;
	localparam logic [4:0]  FU_A_TYPE      = 5'd28;
	localparam logic [4:0]  IDR_TYPE       = 5'd5;
	localparam logic [4:0]  SLICE_TYPE_MAX = 5'd5;

	localparam logic [3:0] REG_MAX_PAYLOAD  = 4'd0;
	localparam logic [3:0] REG_LENGTH_FIELD = 4'd1;

	typedef enum logic [1:0] {
		CMD_ADD,
		CMD_FLUSH,
		CMD_FRAG
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic                   fin;      // group or fragment ends the sample
		logic                   last_out; // last piece of this command ends the item
		logic                   idr;
		logic [3:0]             idx;
		logic [4:0]             count;
		logic [1:0]             nri;
		logic [7:0]             hdr;
		logic [CMD_LEN_W-1:0]   len;
		logic [CMD_OFF_W-1:0]   off;
		logic [15:0]            mp;
	} cmd_t;

endpackage
`default_nettype wire

/* rtl/h264rtp_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module h264rtp_fifo (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  h264rtp_pkg::cmd_t   wr_cmd,
	output logic                full,
	input  wire                 pop,
	output h264rtp_pkg::cmd_t   rd_cmd,
	output logic                empty
);
	h264rtp_pkg::cmd_t mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;

	assign full   = (cnt_q == 3'd4);
	assign empty  = (cnt_q == 3'd0);
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			if (push && !full) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (pop && !empty) rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, push && !full} - {2'd0, pop && !empty};
		end
	end
endmodule
`default_nettype wire

/* rtl/h264rtp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module h264rtp_front #(
	parameter int MAX_GROUP       = 8,
	parameter int OFFSET_BITS     = 20,
	parameter int NAL_LENGTH_BITS = 14
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire [NAL_LENGTH_BITS-1:0]  nal_length,
	input  wire [7:0]                  nal_header,
	input  wire                        last_in_sample,
	input  wire [15:0]                 mp,
	input  wire [2:0]                  lfs,
	output logic                       push,
	output h264rtp_pkg::cmd_t          cmd,
	input  wire                        full
);
	localparam int CW = $clog2(MAX_GROUP + 1);

	logic [CW-1:0]          count_q;
	logic [15:0]            bytes_q;
	logic [1:0]             nri_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [4:0]             fst_q;
	logic [2:0]             pend_q;
	h264rtp_pkg::cmd_t      slot_q [3];

	logic                   accept;
	logic [OFFSET_BITS-1:0] nal_off;
	logic [OFFSET_BITS-1:0] new_pos;
	logic [4:0]             ntype;
	logic [4:0]             fst_n;
	logic                   idr;
	logic                   big;
	logic                   flush1;
	logic [CW-1:0]          count1;
	logic [15:0]            bytes1;
	logic [1:0]             nri1;
	logic [1:0]             nri2;
	logic [17:0]            bsum;
	logic [15:0]            bsat;
	logic [CW-1:0]          count_n;
	logic [15:0]            bytes_n;
	logic [1:0]             nri_n;
	logic [2:0]             pend_n;
	h264rtp_pkg::cmd_t      s0, s1, s2;
	logic [1:0]             sel;

	assign in_stall = |pend_q;
	assign accept   = in_valid && !in_stall;
	assign ntype    = nal_header[4:0];
	assign nal_off  = pos_q + OFFSET_BITS'(lfs);
	assign new_pos  = nal_off + OFFSET_BITS'(nal_length);
	assign fst_n    = (fst_q == 5'd0 && ntype >= 5'd1 && ntype <= h264rtp_pkg::SLICE_TYPE_MAX)
		? ntype : fst_q;
	assign idr      = last_in_sample && (fst_n == h264rtp_pkg::IDR_TYPE);
	assign big      = 17'(nal_length) > 17'(mp);

	always_comb begin
		flush1 = (count_q != '0) &&
			((count_q >= CW'(MAX_GROUP)) ||
			(18'(bytes_q) + 18'd2 + 18'(nal_length) > 18'(mp)));
		count1 = flush1 ? '0 : count_q;
		bytes1 = flush1 ? 16'd0 : bytes_q;
		nri1   = flush1 ? 2'd0 : nri_q;
		nri2   = (nal_header[6:5] > nri1) ? nal_header[6:5] : nri1;
		bsum   = ((count1 == '0) ? 18'd1 : 18'(bytes1)) + 18'd2 + 18'(nal_length);
		bsat   = (bsum > 18'h0FFFF) ? 16'hFFFF : bsum[15:0];

		s0 = '0;
		s1 = '0;
		s2 = '0;
		pend_n = 3'b000;
		// flush of the pending group, never final in slot 0
		s0.kind  = h264rtp_pkg::CMD_FLUSH;
		s0.count = 5'(count_q);
		s0.nri   = nri_q;
		if (big) begin
			pend_n[0]   = (count_q != '0);
			s1.kind     = h264rtp_pkg::CMD_FRAG;
			s1.fin      = last_in_sample;
			s1.last_out = 1'b1;
			s1.idr      = idr;
			s1.hdr      = nal_header;
			s1.len      = 16'(nal_length);
			s1.off      = 32'(nal_off);
			s1.mp       = mp;
			pend_n[1]   = 1'b1;
			count_n     = '0;
			bytes_n     = 16'd0;
			nri_n       = 2'd0;
		end else begin
			pend_n[0]   = flush1;
			s0.last_out = !last_in_sample;
			s1.kind     = h264rtp_pkg::CMD_ADD;
			s1.idx      = 4'(count1);
			s1.len      = 16'(nal_length);
			s1.off      = 32'(nal_off);
			pend_n[1]   = 1'b1;
			s2.kind     = h264rtp_pkg::CMD_FLUSH;
			s2.fin      = 1'b1;
			s2.last_out = 1'b1;
			s2.idr      = idr;
			s2.count    = 5'(count1) + 5'd1;
			s2.nri      = nri2;
			pend_n[2]   = last_in_sample;
			if (last_in_sample) begin
				count_n = '0;
				bytes_n = 16'd0;
				nri_n   = 2'd0;
			end else begin
				count_n = count1 + CW'(1);
				bytes_n = bsat;
				nri_n   = nri2;
			end
		end
	end

	assign sel  = pend_q[0] ? 2'd0 : (pend_q[1] ? 2'd1 : 2'd2);
	assign push = (|pend_q) && !full;
	assign cmd  = slot_q[sel];

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q[0] <= s0;
			slot_q[1] <= s1;
			slot_q[2] <= s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bytes_q <= 16'd0;
			nri_q   <= 2'd0;
			pos_q   <= '0;
			fst_q   <= 5'd0;
			pend_q  <= 3'b000;
		end else if (accept) begin
			count_q <= count_n;
			bytes_q <= bytes_n;
			nri_q   <= nri_n;
			pos_q   <= last_in_sample ? '0 : new_pos;
			fst_q   <= last_in_sample ? 5'd0 : fst_n;
			pend_q  <= pend_n;
		end else if (push) begin
			pend_q[sel] <= 1'b0;
		end
	end
endmodule
`default_nettype wire

/* rtl/h264rtp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module h264rtp_back #(
	parameter int MAX_GROUP       = 8,
	parameter int OFFSET_BITS     = 20,
	parameter int NAL_LENGTH_BITS = 14
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  h264rtp_pkg::cmd_t           cmd,
	input  wire                         empty,
	output logic                        pop,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic                        new_packet,
	output logic                        marker,
	output logic [1:0]                  header_count,
	output logic [23:0]                 header_bytes,
	output logic [OFFSET_BITS-1:0]      data_offset,
	output logic [NAL_LENGTH_BITS-1:0]  data_length,
	output logic                        idr_sample,
	output logic                        last
);
	localparam int GI_W = $clog2(MAX_GROUP);
	localparam int CW   = $clog2(MAX_GROUP + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GROUP,
		ST_FRAG
	} state_t;

	state_t                     state_q;
	logic [NAL_LENGTH_BITS-1:0] len_mem [MAX_GROUP];
	logic [OFFSET_BITS-1:0]     off_mem [MAX_GROUP];
	logic [GI_W-1:0]            i_q;
	logic [CW-1:0]              cnt_q;
	logic [1:0]                 nri_q;
	logic                       fin_q;
	logic                       lastout_q;
	logic                       idr_q;
	logic [NAL_LENGTH_BITS-1:0] rem_q;
	logic [OFFSET_BITS-1:0]     off_q;
	logic [2:0]                 ind_q;
	logic [4:0]                 type_q;
	logic                       first_q;
	logic [15:0]                mp_q;

	logic                       out_valid_q;
	logic                       new_packet_q;
	logic                       marker_q;
	logic [1:0]                 header_count_q;
	logic [23:0]                header_bytes_q;
	logic [OFFSET_BITS-1:0]     data_offset_q;
	logic [NAL_LENGTH_BITS-1:0] data_length_q;
	logic                       idr_sample_q;
	logic                       last_q;

	logic                       adv;
	logic                       grp_end;
	logic [NAL_LENGTH_BITS-1:0] g_len;
	logic [15:0]                g_len16;
	logic                       fend;
	logic [NAL_LENGTH_BITS-1:0] fw;

	assign adv     = !out_valid_q || !out_stall;
	assign pop     = (state_q == ST_IDLE) && !empty;
	assign grp_end = (CW'(i_q) + CW'(1)) == cnt_q;
	assign g_len   = len_mem[i_q];
	assign g_len16 = 16'(g_len);
	assign fend    = (17'(rem_q) + 17'd2) <= 17'(mp_q);
	assign fw      = fend ? rem_q : NAL_LENGTH_BITS'(mp_q - 16'd2);

	always_ff @(posedge clk) begin
		if (pop && cmd.kind == h264rtp_pkg::CMD_ADD) begin
			len_mem[cmd.idx[GI_W-1:0]] <= cmd.len[NAL_LENGTH_BITS-1:0];
			off_mem[cmd.idx[GI_W-1:0]] <= cmd.off[OFFSET_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (adv) out_valid_q <= 1'b0;
					if (pop) begin
						fin_q     <= cmd.fin;
						lastout_q <= cmd.last_out;
						idr_q     <= cmd.idr;
						cnt_q     <= CW'(cmd.count);
						nri_q     <= cmd.nri;
						i_q       <= '0;
						rem_q     <= cmd.len[NAL_LENGTH_BITS-1:0] - NAL_LENGTH_BITS'(1);
						off_q     <= cmd.off[OFFSET_BITS-1:0] + OFFSET_BITS'(1);
						ind_q     <= cmd.hdr[7:5];
						type_q    <= cmd.hdr[4:0];
						first_q   <= 1'b1;
						mp_q      <= cmd.mp;
						if (cmd.kind == h264rtp_pkg::CMD_FLUSH) state_q <= ST_GROUP;
						else if (cmd.kind == h264rtp_pkg::CMD_FRAG) state_q <= ST_FRAG;
					end
				end
				ST_GROUP: begin
					if (adv) begin
						out_valid_q   <= 1'b1;
						data_offset_q <= off_mem[i_q];
						data_length_q <= g_len;
						last_q        <= grp_end && lastout_q;
						idr_sample_q  <= grp_end && idr_q;
						if (cnt_q == CW'(1)) begin
							new_packet_q   <= 1'b1;
							marker_q       <= fin_q;
							header_count_q <= 2'd0;
							header_bytes_q <= 24'd0;
						end else if (i_q == '0) begin
							new_packet_q   <= 1'b1;
							marker_q       <= fin_q;
							header_count_q <= 2'd3;
							header_bytes_q <= {1'b0, nri_q, h264rtp_pkg::STAP_A_TYPE, g_len16};
						end else begin
							new_packet_q   <= 1'b0;
							marker_q       <= 1'b0;
							header_count_q <= 2'd2;
							header_bytes_q <= {8'd0, g_len16};
						end
						i_q <= i_q + GI_W'(1);
						if (grp_end) state_q <= ST_IDLE;
					end
				end
				ST_FRAG: begin
					if (adv) begin
						out_valid_q    <= 1'b1;
						new_packet_q   <= 1'b1;
						marker_q       <= fin_q && fend;
						header_count_q <= 2'd2;
						header_bytes_q <= {8'd0, ind_q, h264rtp_pkg::FU_A_TYPE,
							first_q, fend, 1'b0, type_q};
						data_offset_q  <= off_q;
						data_length_q  <= fw;
						last_q         <= fend && lastout_q;
						idr_sample_q   <= fend && idr_q;
						rem_q          <= rem_q - fw;
						off_q          <= off_q + OFFSET_BITS'(fw);
						first_q        <= 1'b0;
						if (fend) state_q <= ST_IDLE;
					end
				end
				default: begin
					if (adv) out_valid_q <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign new_packet   = new_packet_q;
	assign marker       = marker_q;
	assign header_count = header_count_q;
	assign header_bytes = header_bytes_q;
	assign data_offset  = data_offset_q;
	assign data_length  = data_length_q;
	assign idr_sample   = idr_sample_q;
	assign last         = last_q;
endmodule
`default_nettype wire

/* rtl/h264_rtp_packetizer.sv */
// Path: an accepted NAL descriptor is registered in the front end's command slots, which
// push into the queue while it is not full; the idle packet sequencer pops each command.
// Throughput: one piece per cycle within a command while out_stall is low; a descriptor
// queues up to three commands, stalling input until pushed; its pieces drain behind it.
// Reset (arst_n low, asynchronous): group, sample position and queue clear,
// max_payload returns to 1400 and length_field_size to 4.
`timescale 1ns / 1ps
`default_nettype none
module h264_rtp_packetizer #(
	parameter int MAX_GROUP       = 8,
	parameter int OFFSET_BITS     = 20,
	parameter int NAL_LENGTH_BITS = 14
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire [3:0]                   cfg_index,
	input  wire [15:0]                  cfg_data,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire [NAL_LENGTH_BITS-1:0]   nal_length,
	input  wire [7:0]                   nal_header,
	input  wire                         last_in_sample,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic                        new_packet,
	output logic                        marker,
	output logic [1:0]                  header_count,
	output logic [23:0]                 header_bytes,
	output logic [OFFSET_BITS-1:0]      data_offset,
	output logic [NAL_LENGTH_BITS-1:0]  data_length,
	output logic                        idr_sample,
	output logic                        last
);
	logic [15:0]       max_payload_q;
	logic [2:0]        lfs_q;
	logic [15:0]       mp_eff;
	logic [2:0]        lfs_eff;
	logic              push;
	logic              full;
	logic              empty;
	logic              pop;
	h264rtp_pkg::cmd_t wr_cmd;
	h264rtp_pkg::cmd_t rd_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= 16'd1400;
			lfs_q         <= 3'd4;
		end else if (cfg_valid) begin
			if (cfg_index == h264rtp_pkg::REG_MAX_PAYLOAD) max_payload_q <= cfg_data;
			else if (cfg_index == h264rtp_pkg::REG_LENGTH_FIELD) lfs_q <= cfg_data[2:0];
		end
	end

	assign mp_eff  = (max_payload_q < h264rtp_pkg::MIN_PAYLOAD) ? h264rtp_pkg::MIN_PAYLOAD
		: max_payload_q;
	assign lfs_eff = (lfs_q == 3'd0) ? 3'd1 : ((lfs_q > 3'd4) ? 3'd4 : lfs_q);

	h264rtp_front #(
		.MAX_GROUP(MAX_GROUP),
		.OFFSET_BITS(OFFSET_BITS),
		.NAL_LENGTH_BITS(NAL_LENGTH_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.nal_length(nal_length),
		.nal_header(nal_header),
		.last_in_sample(last_in_sample),
		.mp(mp_eff),
		.lfs(lfs_eff),
		.push(push),
		.cmd(wr_cmd),
		.full(full)
	);

	h264rtp_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_cmd(wr_cmd),
		.full(full),
		.pop(pop),
		.rd_cmd(rd_cmd),
		.empty(empty)
	);

	h264rtp_back #(
		.MAX_GROUP(MAX_GROUP),
		.OFFSET_BITS(OFFSET_BITS),
		.NAL_LENGTH_BITS(NAL_LENGTH_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(rd_cmd),
		.empty(empty),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.new_packet(new_packet),
		.marker(marker),
		.header_count(header_count),
		.header_bytes(header_bytes),
		.data_offset(data_offset),
		.data_length(data_length),
		.idr_sample(idr_sample),
		.last(last)
	);
endmodule
`default_nettype wire

/* rtl/h264rtp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module h264rtp_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_stall,
	input wire        new_packet,
	input wire        marker,
	input wire [1:0]  header_count,
	input wire [23:0] header_bytes,
	input wire        idr_sample,
	input wire        last
);
	// a stalled piece holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(header_bytes))
		else $error("stalled piece changed");

	a_cont_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !new_packet |-> !marker && header_count == 2'd2)
		else $error("continuation piece with marker or wrong header");

	a_no_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_count == 2'd0 |-> header_bytes == 24'd0)
		else $error("header bytes without header count");

	// idr_sample is raised only with last; the final piece of an aggregate is a continuation, so no marker there
	a_idr_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && idr_sample |-> last)
		else $error("idr flag off the final piece");
endmodule

bind h264_rtp_packetizer h264rtp_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.new_packet(new_packet),
	.marker(marker),
	.header_count(header_count),
	.header_bytes(header_bytes),
	.idr_sample(idr_sample),
	.last(last)
);
`default_nettype wire
